// ----- hw/rtl/djc_pkg.sv -----
// Shared types, constants and the JET color function for the disparity colorizer.
// Used by djc_div_stage, disparity_jet_colorizer and djc_checker; depends on nothing else.
`default_nettype none

package djc_pkg;

    // Field widths
    localparam int DISP_W   = 16;                 // disparity sample, 1/16 pixel
    localparam int CFG_W    = 12;                 // configuration register width
    localparam int FRAC_W   = 4;                  // times 16
    localparam int SPAN_W   = CFG_W + FRAC_W;     // span in 1/16 pixel
    localparam int COLOR_W  = 8;
    localparam int QUO_W    = 8;                  // color index bits
    localparam int SCALE_W  = 8;                  // times 255 = times 256 minus one
    localparam int REM_W    = DISP_W + SCALE_W;   // scaled difference
    localparam int DIV_STAGES      = 4;
    localparam int STEPS_PER_STAGE = QUO_W / DIV_STAGES;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] LOW_RESET   = 12'd0;
    localparam logic [CFG_W-1:0] RANGE_RESET = 12'd128;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_LOW   = 1'b0,
        REG_RANGE = 1'b1
    } cfg_reg_t;

    // Item state inside the divider stages
    typedef struct packed {
        logic [REM_W-1:0] rem;    // partial remainder, shifted left each step
        logic [QUO_W-1:0] quo;    // quotient bits, MSB first
        logic             skip;   // black or clamped: no division needed
        logic             black;
        logic             last;
    } div_t;

    typedef struct packed {
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
    } rgb_t;

    // Rising ramp: 4,8,...,128 then 131,135,...,255
    function automatic logic [COLOR_W-1:0] ramp_up(input logic [5:0] k);
        logic [5:0] k1;
        k1 = {1'b0, k[4:0]} + 6'd1;
        if (!k[5])
            ramp_up = {k1, 2'b00};
        else
            ramp_up = 8'd131 + {1'b0, k[4:0], 2'b00};
    endfunction

    // Falling ramp: 251,...,4,0
    function automatic logic [COLOR_W-1:0] ramp_down(input logic [5:0] k);
        if (k == 6'd63)
            ramp_down = '0;
        else
            ramp_down = ramp_up(6'd62 - k);
    endfunction

    // JET color of an 8-bit index
    function automatic rgb_t jet_color(input logic [QUO_W-1:0] i);
        rgb_t c;
        logic [5:0] k;
        k = i[5:0];
        if (i < 8'd32) begin
            c.r = '0;  c.g = '0;  c.b = ramp_up(k + 6'd32);
        end else if (i < 8'd96) begin
            c.r = '0;  c.g = ramp_up(k - 6'd32);  c.b = 8'd255;
        end else if (i < 8'd160) begin
            c.r = ramp_up(k - 6'd32);  c.g = 8'd255;  c.b = ramp_down(k - 6'd32);
        end else if (i < 8'd224) begin
            c.r = 8'd255;  c.g = ramp_down(k - 6'd32);  c.b = '0;
        end else begin
            c.r = ramp_down(k - 6'd32);  c.g = '0;  c.b = '0;
        end
        jet_color = c;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/djc_div_stage.sv -----
// One pipeline stage of the restoring divider: two quotient bits per stage.
// Depends on djc_pkg (div_t, widths).
`default_nettype none

module djc_div_stage
    import djc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SPAN_W-1:0] divisor,
    input  wire logic              up_valid,
    output logic                   up_ready,
    input  wire div_t              up_data,
    output logic                   down_valid,
    input  wire logic              down_ready,
    output div_t                   down_data
);

    logic             valid_reg;
    div_t             data_reg;
    div_t             data_next;
    logic [REM_W-1:0] dvs_top;

    // Divisor aligned with the top quotient bit
    assign dvs_top = {1'b0, divisor, {(QUO_W-1){1'b0}}};

    // Compare, subtract, shift
    always_comb
    begin
        data_next = up_data;
        if (!up_data.skip)
        begin
            for (int s = 0; s < STEPS_PER_STAGE; s++)
            begin
                if (data_next.rem >= dvs_top)
                begin
                    data_next.rem = data_next.rem - dvs_top;
                    data_next.quo = {data_next.quo[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    data_next.quo = {data_next.quo[QUO_W-2:0], 1'b0};
                end
                data_next.rem = {data_next.rem[REM_W-2:0], 1'b0};
            end
        end
    end

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/disparity_jet_colorizer.sv -----
// Top level of the disparity to JET pseudocolor converter.
// Depends on djc_pkg and djc_div_stage.
//
// Usage:
//   Input channel (in_valid / in_stall): one signed disparity sample in
//   1/16 pixel plus a last-pixel flag per transfer. Output channel
//   (out_valid / out_stall): red, green, blue and the copied flag.
//   Configuration channel (cfg_valid / cfg_ready, always ready): index 0
//   writes the lower bound in whole pixels, index 1 the span in whole
//   pixels; write only while the pipeline is empty.
//   Eight register stages: difference, scale by 255, clamp check, four
//   divider stages of two quotient bits each, then the color table into
//   the output register. Throughput is one pixel per cycle while the
//   receiver does not stall; the divider stages set the depth.
//   When the receiver stalls, each stage holds once its successor is full,
//   bubbles are squeezed out, and in_stall rises only when the pipeline is
//   full. Reset empties the pipeline and restores a lower bound of 0 and a
//   span of 128 pixels.
`default_nettype none

module disparity_jet_colorizer
    import djc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    // pixel input
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [DISP_W-1:0]  disparity,
    input  wire logic               last_pixel,
    // color output
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [COLOR_W-1:0]      red,
    output logic [COLOR_W-1:0]      green,
    output logic [COLOR_W-1:0]      blue,
    output logic                    last_pixel_out
);

    // Configuration registers
    logic [CFG_W-1:0]  low_reg;
    logic [CFG_W-1:0]  range_reg;
    logic [DISP_W-1:0] lower;
    logic [SPAN_W-1:0] span;

    assign cfg_ready = 1'b1;
    assign lower     = {low_reg, {FRAC_W{1'b0}}};
    assign span      = {range_reg, {FRAC_W{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg   <= LOW_RESET;
            range_reg <= RANGE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LOW:   low_reg   <= cfg_data;
                REG_RANGE: range_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: difference to the lower bound and black detection
    logic              s1_valid_reg;
    logic [DISP_W-1:0] s1_diff_reg;
    logic              s1_black_reg;
    logic              s1_last_reg;
    logic              s1_ready;
    logic [DISP_W-1:0] diff_next;
    logic              black_next;

    // above the bound the true difference is 1..65535, exact in 16 bits
    assign diff_next  = disparity - lower;
    assign black_next = !($signed(disparity) > $signed(lower)) || (range_reg == '0);

    // Stage 2: scale by 255
    logic              s2_valid_reg;
    logic [REM_W-1:0]  s2_prod_reg;
    logic              s2_black_reg;
    logic              s2_last_reg;
    logic              s2_ready;
    logic [REM_W-1:0]  prod_next;

    assign prod_next = {s1_diff_reg, {SCALE_W{1'b0}}} - {{SCALE_W{1'b0}}, s1_diff_reg};

    // Stage 3: clamp check, seeds the divider
    logic              s3_valid_reg;
    div_t              s3_data_reg;
    div_t              s3_data_next;
    logic              s3_ready;
    logic [REM_W-1:0]  span_full;

    assign span_full = {span, {QUO_W{1'b0}}};

    always_comb
    begin
        s3_data_next.rem   = s2_prod_reg;
        s3_data_next.black = s2_black_reg;
        s3_data_next.last  = s2_last_reg;
        if (!s2_black_reg && s2_prod_reg >= span_full)
        begin
            s3_data_next.quo  = '1;
            s3_data_next.skip = 1'b1;
        end
        else
        begin
            s3_data_next.quo  = '0;
            s3_data_next.skip = s2_black_reg;
        end
    end

    // Divider chain
    logic div_valid [0:DIV_STAGES];
    logic div_ready [0:DIV_STAGES];
    div_t div_data  [0:DIV_STAGES];
    logic out_ready;

    assign div_valid[0] = s3_valid_reg;
    assign div_data[0]  = s3_data_reg;
    assign s3_ready     = !s3_valid_reg || div_ready[0];
    assign div_ready[DIV_STAGES] = out_ready;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        djc_div_stage u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .divisor    (span),
            .up_valid   (div_valid[g]),
            .up_ready   (div_ready[g]),
            .up_data    (div_data[g]),
            .down_valid (div_valid[g+1]),
            .down_ready (div_ready[g+1]),
            .down_data  (div_data[g+1])
        );
    end

    // Handshake chain for the front stages
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            if (s3_ready)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_diff_reg  <= diff_next;
            s1_black_reg <= black_next;
            s1_last_reg  <= last_pixel;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_prod_reg  <= prod_next;
            s2_black_reg <= s1_black_reg;
            s2_last_reg  <= s1_last_reg;
        end
        if (s3_ready && s2_valid_reg)
            s3_data_reg <= s3_data_next;
    end

    // Output register: color table lookup
    logic out_valid_reg;
    rgb_t out_rgb_reg;
    rgb_t rgb_next;
    logic out_last_reg;

    always_comb
    begin
        if (div_data[DIV_STAGES].black)
            rgb_next = '0;
        else
            rgb_next = jet_color(div_data[DIV_STAGES].quo);
    end

    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_ready)
            out_valid_reg <= div_valid[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && div_valid[DIV_STAGES])
        begin
            out_rgb_reg  <= rgb_next;
            out_last_reg <= div_data[DIV_STAGES].last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign red            = out_rgb_reg.r;
    assign green          = out_rgb_reg.g;
    assign blue           = out_rgb_reg.b;
    assign last_pixel_out = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/djc_checker.sv -----
// Port-level checks for disparity_jet_colorizer, bound to every instance.
// Depends on djc_pkg for widths.
`default_nettype none

module djc_checker
    import djc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [COLOR_W-1:0] red,
    input wire logic [COLOR_W-1:0] green,
    input wire logic [COLOR_W-1:0] blue,
    input wire logic               last_pixel_out
);

    // Pipeline holds at most this many pixels
    localparam int DEPTH = 4 + DIV_STAGES;

    logic [3:0] pend_reg;
    logic [3:0] pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid && !out_stall;
    assign pend_next = pend_reg + {3'b0, in_xfer} - {3'b0, out_xfer};

    // Pixels in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
                                   && $stable(blue) && $stable(last_pixel_out))
        else $error("output changed while stalled");

    // No result without a pixel behind it
    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result without an input pixel");

    // Never more pixels in flight than stages
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 4'(DEPTH))
        else $error("more pixels in flight than pipeline stages");

    // JET colors never pair full blue with red, or full red with blue
    a_jet_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (blue != 8'd255 || red == 8'd0) && (red != 8'd255 || blue == 8'd0))
        else $error("color outside the JET ramp");

endmodule

bind disparity_jet_colorizer djc_checker u_djc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .last_pixel_out (last_pixel_out)
);

`default_nettype wire
